/* hdl/usb_transfer_descriptor_builder_core_assert.svh */
// assertion macros for the transfer descriptor builder
// expects clk and rst_n in the scope that uses them
`ifndef USB_TRANSFER_DESCRIPTOR_BUILDER_CORE_ASSERT_SVH
`define USB_TRANSFER_DESCRIPTOR_BUILDER_CORE_ASSERT_SVH

// same-cycle implication
`define UTDB_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define UTDB_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* hdl/utdb_pkg.sv */
// shared types, constants and helpers for the transfer descriptor builder
// no dependencies
package utdb_pkg;

    localparam int MAX_DESCRIPTORS = 32;
    localparam int CNT_W           = $clog2(MAX_DESCRIPTORS + 1);

    localparam logic [7:0] PID_IN    = 8'h69;
    localparam logic [7:0] PID_OUT   = 8'he1;
    localparam logic [7:0] PID_SETUP = 8'h2d;

    localparam logic [31:0] CS_ACTIVE = 32'h1 << 23;
    localparam logic [31:0] CS_LOWSPD = 32'h1 << 26;
    localparam logic [31:0] CS_ERR3   = 32'h3 << 27;

    localparam logic [1:0] SRC_SETUP = 2'd0;
    localparam logic [1:0] SRC_DATA  = 2'd1;
    localparam logic [1:0] SRC_NONE  = 2'd2;

    localparam logic [10:0] MAXLEN_SETUP = 11'd7;
    localparam logic [10:0] MAXLEN_NULL  = 11'h7ff;

    typedef enum logic [1:0] {
        TD_SETUP,
        TD_DATA,
        TD_STATUS,
        TD_INTR
    } td_kind_t;

    typedef struct packed {
        logic        mode;
        logic        speed_low;
        logic [6:0]  device_address;
        logic [3:0]  endpoint;
        logic        start_toggle;
        logic [7:0]  request_type;
        logic [15:0] data_length;
        logic [9:0]  max_packet;
    } utdb_request_t;

    typedef struct packed {
        logic [31:0] status_word;
        logic [31:0] token_word;
        logic [1:0]  buffer_source;
        logic [15:0] data_offset;
        logic        last;
        logic        overflow;
    } utdb_result_t;

    typedef struct packed {
        logic     load;
        logic     emit;
        td_kind_t kind;
        logic     last;
        logic     overflow;
    } utdb_cmd_t;

    typedef struct packed {
        logic req_intr;
        logic len_zero;
        logic data_done;
        logic pool_end;
    } utdb_stat_t;

    function automatic logic [31:0] make_token(
        input logic [10:0] maxlen,
        input logic        toggle,
        input logic [3:0]  ep,
        input logic [6:0]  addr,
        input logic [7:0]  pid
    );
        return {maxlen, 1'b0, toggle, ep, addr, pid};
    endfunction

endpackage

/* hdl/utdb_ctrl.sv */
// controller: steps through setup, data and status descriptors, or a single interrupt descriptor
// depends on utdb_pkg
module utdb_ctrl
    import utdb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  utdb_stat_t stat,
    output utdb_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SETUP  = 5'b00010,
        S_DATA   = 5'b00100,
        S_STATUS = 5'b01000,
        S_INTR   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.emit     = 1'b0;
        cmd.kind     = TD_SETUP;
        cmd.last     = 1'b0;
        cmd.overflow = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = stat.req_intr ? S_INTR : S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.emit   = 1'b1;
                cmd.kind   = TD_SETUP;
                state_next = stat.len_zero ? S_STATUS : S_DATA;
            end
            S_DATA:
            begin
                cmd.emit     = 1'b1;
                cmd.kind     = TD_DATA;
                cmd.last     = stat.pool_end;
                cmd.overflow = stat.pool_end;
                if (stat.pool_end)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.data_done)
                begin
                    state_next = S_STATUS;
                end
            end
            S_STATUS:
            begin
                cmd.emit   = 1'b1;
                cmd.kind   = TD_STATUS;
                cmd.last   = 1'b1;
                state_next = S_IDLE;
            end
            S_INTR:
            begin
                cmd.emit   = 1'b1;
                cmd.kind   = TD_INTR;
                cmd.last   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* hdl/utdb_datapath.sv */
// datapath: request capture, offset, toggle and count, descriptor formatting
// depends on utdb_pkg
module utdb_datapath
    import utdb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  utdb_request_t request,
    input  utdb_cmd_t     cmd,
    output utdb_stat_t    stat,
    output utdb_result_t  result,
    output logic          done
);

    logic        low_reg;
    logic [6:0]  addr_reg;
    logic [3:0]  ep_reg;
    logic        intr_tog_reg;
    logic        dir_in_reg;
    logic [15:0] len_reg;
    logic [9:0]  mp_reg;
    logic [15:0] off_reg, off_next;
    logic        tog_reg;
    logic [CNT_W-1:0] cnt_reg;
    utdb_result_t result_reg, result_next;
    logic        done_reg;

    logic [15:0] remain;
    logic [9:0]  size;
    logic [15:0] intr_len_m1;
    logic [31:0] cs_word;

    assign remain      = len_reg - off_reg;
    assign intr_len_m1 = len_reg - 16'd1;
    assign size        = stat.data_done ? remain[9:0] : mp_reg;
    assign off_next    = off_reg + {6'd0, size};
    assign cs_word     = CS_ERR3 | CS_ACTIVE | (low_reg ? CS_LOWSPD : 32'd0);

    assign stat.req_intr  = request.mode;
    assign stat.len_zero  = (len_reg == 16'd0);
    assign stat.data_done = ({6'd0, mp_reg} >= remain);
    assign stat.pool_end  = (cnt_reg == CNT_W'(MAX_DESCRIPTORS - 1));

    always_comb
    begin
        result_next.status_word = cs_word;
        result_next.last        = cmd.last;
        result_next.overflow    = cmd.overflow;
        unique case (cmd.kind)
            TD_SETUP:
            begin
                result_next.token_word    = make_token(MAXLEN_SETUP, 1'b0, 4'd0,
                                                       addr_reg, PID_SETUP);
                result_next.buffer_source = SRC_SETUP;
                result_next.data_offset   = 16'd0;
            end
            TD_DATA:
            begin
                result_next.token_word    = make_token({1'b0, size} - 11'd1, tog_reg, 4'd0,
                                                       addr_reg,
                                                       dir_in_reg ? PID_IN : PID_OUT);
                result_next.buffer_source = SRC_DATA;
                result_next.data_offset   = off_reg;
            end
            TD_STATUS:
            begin
                result_next.token_word    = make_token(MAXLEN_NULL, 1'b1, 4'd0, addr_reg,
                                                       dir_in_reg ? PID_OUT : PID_IN);
                result_next.buffer_source = SRC_NONE;
                result_next.data_offset   = 16'd0;
            end
            TD_INTR:
            begin
                result_next.token_word    = make_token(intr_len_m1[10:0], intr_tog_reg,
                                                       ep_reg, addr_reg, PID_IN);
                result_next.buffer_source = SRC_DATA;
                result_next.data_offset   = 16'd0;
            end
            default:
            begin
                result_next.token_word    = 32'd0;
                result_next.buffer_source = SRC_NONE;
                result_next.data_offset   = 16'd0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.emit)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            low_reg      <= request.speed_low;
            addr_reg     <= request.device_address;
            ep_reg       <= request.endpoint;
            intr_tog_reg <= request.start_toggle;
            dir_in_reg   <= request.request_type[7];
            len_reg      <= request.data_length;
            mp_reg       <= (request.max_packet == 10'd0) ? 10'd1 : request.max_packet;
            off_reg      <= 16'd0;
            tog_reg      <= 1'b1;
        end
        else if (cmd.emit && (cmd.kind == TD_DATA))
        begin
            off_reg <= off_next;
            tog_reg <= ~tog_reg;
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

/* hdl/usb_transfer_descriptor_builder_core.sv */
// top level of the transfer descriptor builder
// depends on utdb_pkg, utdb_ctrl, utdb_datapath and the assertion macro header

// A request is accepted when start is high and busy is low; the block then
// emits one transfer descriptor per cycle, each shown on result for exactly
// one cycle with done high, since the receiver cannot stall. A request yields
// 1 descriptor for an interrupt request and 2 + ceil(data_length / max_packet)
// for a control request (a zero max_packet counts as 1), capped at
// MAX_DESCRIPTORS (32). Results are registered and appear in the cycle after
// they are formed; busy drops in the cycle the final result is shown, and the
// next request may be accepted at the end of that same cycle.
module usb_transfer_descriptor_builder_core
    import utdb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  utdb_request_t request,
    output utdb_result_t  result,
    output logic          done
);

    utdb_cmd_t  cmd;
    utdb_stat_t stat;

    utdb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    utdb_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result),
        .done    (done)
    );

`include "usb_transfer_descriptor_builder_core_assert.svh"

    `UTDB_ASSERT_NOW(a_end_marks_last, $fell(busy), done && result.last, "chain end without last")
    `UTDB_ASSERT_NOW(a_ovf_is_last, done && result.overflow, result.last, "overflow not on last")
    `UTDB_ASSERT_NOW(a_mid_keeps_busy, done && !result.last, busy, "idle in mid chain")
    `UTDB_ASSERT_NEXT(a_gap_after_last, done && result.last, !done, "result right after last")

endmodule

/* dv/usb_transfer_descriptor_builder_core_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for usb_transfer_descriptor_builder_core
// predicts each descriptor chain in a scoreboard class; depends on utdb_pkg and the rtl
module usb_transfer_descriptor_builder_core_tb;
    import utdb_pkg::*;

    localparam logic MODE_CONTROL  = 1'b0;
    localparam logic MODE_INTR     = 1'b1;
    localparam int   IDLE_LIMIT    = 600;
    localparam int   TAIL_CYCLES   = 40;
    localparam int   RANDOM_ITEMS  = 300;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    utdb_request_t request;
    utdb_result_t  result;
    logic          done;

    class td_scoreboard;
        utdb_result_t td_expected[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        function logic [31:0] td_token(int unsigned nbytes, logic tog, logic [3:0] ep,
                                       logic [6:0] addr, logic [7:0] pid);
            logic [31:0] m;
            m = nbytes - 1;
            return {m[10:0], 1'b0, tog, ep, addr, pid};
        endfunction

        function void note_request(utdb_request_t rq);
            utdb_result_t chain[$];
            utdb_result_t td;
            logic [31:0]  cs;
            int unsigned  mp;
            int unsigned  len;
            int unsigned  off;
            int unsigned  sz;
            logic         tog;
            logic         cut;
            logic [7:0]   data_pid;
            logic [7:0]   stat_pid;
            cs  = CS_ERR3 | CS_ACTIVE | (rq.speed_low ? CS_LOWSPD : 32'h0);
            mp  = (rq.max_packet == 10'd0) ? 32'd1 : 32'(rq.max_packet);
            len = 32'(rq.data_length);
            cut = 1'b0;
            td  = '0;
            td.status_word = cs;
            if (rq.mode == MODE_INTR)
            begin
                td.token_word    = td_token(len, rq.start_toggle, rq.endpoint,
                                            rq.device_address, PID_IN);
                td.buffer_source = SRC_DATA;
                chain.push_back(td);
            end
            else
            begin
                data_pid = rq.request_type[7] ? PID_IN : PID_OUT;
                stat_pid = rq.request_type[7] ? PID_OUT : PID_IN;
                td.token_word    = td_token(8, 1'b0, 4'h0, rq.device_address, PID_SETUP);
                td.buffer_source = SRC_SETUP;
                chain.push_back(td);
                off = 0;
                tog = 1'b0;
                while (off < len && !cut)
                begin
                    if (chain.size() >= MAX_DESCRIPTORS)
                        cut = 1'b1;
                    else
                    begin
                        tog = ~tog;
                        sz  = (len - off > mp) ? mp : len - off;
                        td.token_word    = td_token(sz, tog, 4'h0, rq.device_address, data_pid);
                        td.buffer_source = SRC_DATA;
                        td.data_offset   = off[15:0];
                        chain.push_back(td);
                        off += sz;
                    end
                end
                if (!cut)
                begin
                    if (chain.size() >= MAX_DESCRIPTORS)
                        cut = 1'b1;
                    else
                    begin
                        td.token_word    = td_token(0, 1'b1, 4'h0, rq.device_address, stat_pid);
                        td.buffer_source = SRC_NONE;
                        td.data_offset   = '0;
                        chain.push_back(td);
                    end
                end
            end
            td          = chain.pop_back();
            td.last     = 1'b1;
            td.overflow = cut;
            chain.push_back(td);
            foreach (chain[k])
                td_expected.push_back(chain[k]);
        endfunction

        function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v)
            begin
                $error("%s: expected %0h, got %0h", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_descriptor(utdb_result_t got);
            utdb_result_t want;
            if (td_expected.size() == 0)
            begin
                $error("descriptor with no transaction pending: %h", got);
                errors++;
            end
            else
            begin
                want = td_expected.pop_front();
                compare_field("status_word", want.status_word, got.status_word);
                compare_field("token_word", want.token_word, got.token_word);
                compare_field("buffer_source", 32'(want.buffer_source),
                              32'(got.buffer_source));
                compare_field("data_offset", 32'(want.data_offset), 32'(got.data_offset));
                compare_field("last", 32'(want.last), 32'(got.last));
                compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
            end
        endfunction
    endclass

    td_scoreboard board = new();
    int           idle_cycles;

    usb_transfer_descriptor_builder_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .result  (result),
        .done    (done)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_descriptor(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function utdb_request_t mk_req(logic mode, int low, int addr, int ep, int tog,
                                   int rtype, int len, int mp);
        utdb_request_t rq;
        rq.mode           = mode;
        rq.speed_low      = 1'(low);
        rq.device_address = 7'(addr);
        rq.endpoint       = 4'(ep);
        rq.start_toggle   = 1'(tog);
        rq.request_type   = 8'(rtype);
        rq.data_length    = 16'(len);
        rq.max_packet     = 10'(mp);
        return rq;
    endfunction

    task automatic send_request(input utdb_request_t rq, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        do @(posedge clk); while (busy !== 1'b0);
        board.note_request(rq);
    endtask

    task automatic wait_chain_drained();
        while (board.td_expected.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        utdb_request_t directed[$];
        utdb_request_t rq;
        int            mp_eff;
        int            len;
        bit            burst;
        idle_cycles = 0;
        start   <= 1'b0;
        request <= '0;
        rst_n   <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(mk_req(MODE_CONTROL, 0, 0, 0, 0, 8'h00, 0, 64));
        directed.push_back(mk_req(MODE_CONTROL, 1, 127, 0, 0, 8'h80, 0, 64));
        directed.push_back(mk_req(MODE_CONTROL, 0, 5, 0, 0, 8'hff, 8, 8));
        directed.push_back(mk_req(MODE_CONTROL, 1, 42, 0, 0, 8'h7f, 3, 2));
        directed.push_back(mk_req(MODE_CONTROL, 0, 1, 0, 0, 8'h80, 1, 1023));
        directed.push_back(mk_req(MODE_CONTROL, 0, 9, 0, 0, 8'h00, 5, 0));
        directed.push_back(mk_req(MODE_CONTROL, 0, 17, 0, 0, 8'h80, 30 * 16, 16));
        directed.push_back(mk_req(MODE_CONTROL, 1, 18, 0, 0, 8'h00, 31 * 16, 16));
        directed.push_back(mk_req(MODE_CONTROL, 0, 19, 0, 0, 8'h80, 31 * 16 + 1, 16));
        directed.push_back(mk_req(MODE_CONTROL, 0, 100, 0, 0, 8'h00, 65535, 1));
        directed.push_back(mk_req(MODE_CONTROL, 1, 127, 0, 0, 8'hff, 65535, 1023));
        directed.push_back(mk_req(MODE_CONTROL, 0, 64, 15, 1, 8'h21, 100, 10));
        directed.push_back(mk_req(MODE_INTR, 0, 0, 0, 0, 8'h00, 0, 0));
        directed.push_back(mk_req(MODE_INTR, 1, 127, 15, 1, 8'h80, 1, 1));
        directed.push_back(mk_req(MODE_INTR, 0, 33, 7, 0, 8'h00, 2048, 8));
        directed.push_back(mk_req(MODE_INTR, 1, 66, 8, 1, 8'h55, 2049, 512));
        directed.push_back(mk_req(MODE_INTR, 0, 3, 1, 0, 8'hff, 65535, 1023));
        directed.push_back(mk_req(MODE_INTR, 0, 85, 0, 0, 8'haa, 64, 0));
        foreach (directed[k])
            send_request(directed[k], $urandom_range(0, 17));
        start <= 1'b0;
        wait_chain_drained();

        burst = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
                burst = 1'($urandom_range(0, 1));
            if (i == RANDOM_ITEMS / 2)
            begin
                start <= 1'b0;
                wait_chain_drained();
            end
            rq.mode           = ($urandom_range(0, 3) == 0) ? MODE_INTR : MODE_CONTROL;
            rq.speed_low      = 1'($urandom_range(0, 1));
            rq.device_address = 7'($urandom);
            rq.endpoint       = 4'($urandom);
            rq.start_toggle   = 1'($urandom_range(0, 1));
            rq.request_type   = 8'($urandom);
            case ($urandom_range(0, 3))
                0:       rq.max_packet = 10'($urandom_range(1, 8));
                1:       rq.max_packet = 10'($urandom_range(1, 64));
                default: rq.max_packet = 10'($urandom);
            endcase
            mp_eff = (rq.max_packet == 10'd0) ? 1 : int'(rq.max_packet);
            case ($urandom_range(0, 4))
                0:       len = int'($urandom_range(0, 16));
                1:       len = mp_eff * int'($urandom_range(28, 31))
                               + int'($urandom_range(0, mp_eff));
                2:       len = int'($urandom_range(0, mp_eff * 8));
                default: len = int'($urandom_range(0, 65535));
            endcase
            rq.data_length = (len > 65535) ? 16'hffff : 16'(len);
            send_request(rq, burst ? 0 : $urandom_range(0, 17));
        end
        start <= 1'b0;
        wait_chain_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
